FILE: src/teq_pkg.sv
package teq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_CAP = (MAX_RESULTS < QUEUE_DEPTH) ? MAX_RESULTS : QUEUE_DEPTH;
  localparam logic [CNT_W-1:0] RES_CAP_C = CNT_W'(RES_CAP);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_EXPIRE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_CREATED   = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_CANCELLED = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_EXPIRED   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_C_RD,
    S_C_CHK,
    S_C_INS,
    S_X_RD,
    S_X_CHK,
    S_E_RD,
    S_E_CHK,
    S_F_RD,
    S_F_OUT,
    S_M_RD,
    S_M_WR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [63:0] expiry;
    logic [31:0] id;
    logic [31:0] handle;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } store_req_t;

endpackage

FILE: src/teq_store.sv
module teq_store
  import teq_pkg::*;
(
  input  logic       clk_i,
  input  store_req_t req_i,
  output entry_t     rdata_o
);

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/timer_event_queue.sv
// Sorted timer event queue.
// Slave channel: one request per handshake. tuser holds the command (create,
// cancel, expire); tdata holds expire_time, handle, target_id and now_time.
// Master channel: results. Create and cancel give one result; expire gives
// one result per popped event (up to MAX_RESULTS), or one "none" result.
// tlast marks the final result of a request. Every result carries the head
// of the queue as it stands once the whole request is done.
// Steps: create examines entries from the tail (every moved entry and the
// one the walk stops at), then inserts. Cancel walks all queued entries.
// Expire scans the due entries and the first one not yet due, emits each
// popped event, then moves the remaining entries down. The one read port
// of the entry store sets the pace.
// tready stays low while a request is in progress.
// A stalled receiver holds the result in the output register and stalls the
// walk; no result is dropped.
// Reset empties the queue and clears the id counter; no clearing pass runs.
module timer_event_queue
  import teq_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // expire_time[63:0], handle[95:64], target_id[127:96], now_time[191:128]
  input  logic [191:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // id[31:0], out_handle[63:32], head_valid[64], head_time[128:65], zero[135:129]
  output logic [135:0] m_axis_tdata,
  // status[2:0], fired[3]
  output logic [3:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  state_e           state_q, state_d;
  logic [63:0]      time_q, time_d;
  logic [31:0]      handle_q, handle_d;
  logic [31:0]      tid_q, tid_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0]      next_id_q, next_id_d;
  logic [63:0]      head_q, head_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] due_q, due_d;
  logic             found_q, found_d;
  status_e          res_status_q, res_status_d;
  logic [31:0]      res_id_q, res_id_d;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [31:0]      out_id_q, out_handle_q;
  logic             out_fired_q, out_hv_q, out_last_q;
  logic [63:0]      out_head_q;

  store_req_t       req;
  entry_t           rd;
  logic             in_fire, out_ready;
  logic             due_now, match, scan_last;
  logic [CNT_W-1:0] due_total;

  logic             out_load;
  status_e          ld_status;
  logic [31:0]      ld_id, ld_handle;
  logic             ld_fired, ld_last;

  teq_store u_store (
    .clk_i  (clk_i),
    .req_i  (req),
    .rdata_o(rd)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_ready     = !out_valid_q || m_axis_tready;

  assign due_now   = (rd.expiry <= time_q) && (ptr_q < RES_CAP_C);
  assign due_total = due_now ? ptr_q + CNT_W'(1) : ptr_q;
  assign match     = (rd.id == tid_q);
  assign scan_last = (ptr_q + CNT_W'(1) == count_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser)
            CMD_CREATE: begin
              if (count_q == DEPTH_C) state_d = S_RESP;
              else if (count_q == '0) state_d = S_C_INS;
              else state_d = S_C_RD;
            end
            CMD_CANCEL: state_d = (count_q == '0) ? S_RESP : S_X_RD;
            CMD_EXPIRE: state_d = (count_q == '0) ? S_RESP : S_E_RD;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_C_RD:  state_d = S_C_CHK;
      S_C_CHK: begin
        if (rd.expiry > time_q && ptr_q != CNT_W'(1)) state_d = S_C_RD;
        else state_d = S_C_INS;
      end
      S_C_INS: state_d = S_RESP;
      S_X_RD:  state_d = S_X_CHK;
      S_X_CHK: state_d = scan_last ? S_RESP : S_X_RD;
      S_E_RD:  state_d = S_E_CHK;
      S_E_CHK: begin
        if (due_now && !scan_last) state_d = S_E_RD;
        else if (due_total == '0) state_d = S_RESP;
        else state_d = S_F_RD;
      end
      S_F_RD:  state_d = S_F_OUT;
      S_F_OUT: begin
        if (out_ready) begin
          if (ptr_q + CNT_W'(1) == due_q) state_d = (count_q == '0) ? S_IDLE : S_M_RD;
          else state_d = S_F_RD;
        end
      end
      S_M_RD:  state_d = S_M_WR;
      S_M_WR:  state_d = scan_last ? S_IDLE : S_M_RD;
      S_RESP:  state_d = out_ready ? S_IDLE : S_RESP;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    time_d       = time_q;
    handle_d     = handle_q;
    tid_d        = tid_q;
    count_d      = count_q;
    next_id_d    = next_id_q;
    head_d       = head_q;
    ptr_d        = ptr_q;
    due_d        = due_q;
    found_d      = found_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    req.we       = 1'b0;
    req.waddr    = ptr_q[IDX_W-1:0];
    req.wdata    = rd;
    req.raddr    = ptr_q[IDX_W-1:0];
    out_load     = 1'b0;
    ld_status    = res_status_q;
    ld_id        = res_id_q;
    ld_handle    = '0;
    ld_fired     = 1'b0;
    ld_last      = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          time_d   = (s_axis_tuser == CMD_CREATE) ? s_axis_tdata[63:0] : s_axis_tdata[191:128];
          handle_d = s_axis_tdata[95:64];
          tid_d    = s_axis_tdata[127:96];
          ptr_d    = (s_axis_tuser == CMD_CREATE) ? count_q : '0;
          found_d  = 1'b0;
          case (s_axis_tuser)
            CMD_CREATE: begin
              res_status_d = STAT_FULL;
              res_id_d     = '0;
            end
            CMD_CANCEL: begin
              res_status_d = STAT_NOT_FOUND;
              res_id_d     = s_axis_tdata[127:96];
            end
            default: begin
              res_status_d = STAT_EXPIRED;
              res_id_d     = '0;
            end
          endcase
        end
      end
      S_C_RD: req.raddr = IDX_W'(ptr_q - CNT_W'(1));
      S_C_CHK: begin
        if (rd.expiry > time_q) begin
          req.we = 1'b1;
          ptr_d  = ptr_q - CNT_W'(1);
        end
      end
      S_C_INS: begin
        req.we       = 1'b1;
        req.wdata    = '{expiry: time_q, id: next_id_q, handle: handle_q};
        count_d      = count_q + CNT_W'(1);
        if (ptr_q == '0) head_d = time_q;
        res_status_d = STAT_CREATED;
        res_id_d     = next_id_q;
        next_id_d    = next_id_q + 32'd1;
      end
      S_X_CHK: begin
        // shift every entry after the match down by one
        if (found_q) begin
          req.we    = 1'b1;
          req.waddr = IDX_W'(ptr_q - CNT_W'(1));
          if (ptr_q == CNT_W'(1)) head_d = rd.expiry;
        end
        found_d = found_q || match;
        ptr_d   = ptr_q + CNT_W'(1);
        if (scan_last) begin
          res_status_d = (found_q || match) ? STAT_CANCELLED : STAT_NOT_FOUND;
          res_id_d     = tid_q;
          if (found_q || match) count_d = count_q - CNT_W'(1);
        end
      end
      S_E_CHK: begin
        if (due_now) ptr_d = ptr_q + CNT_W'(1);
        else head_d = rd.expiry;
        if (!due_now || scan_last) begin
          due_d        = due_total;
          count_d      = count_q - due_total;
          ptr_d        = '0;
          res_status_d = STAT_EXPIRED;
          res_id_d     = '0;
        end
      end
      S_F_OUT: begin
        if (out_ready) begin
          out_load  = 1'b1;
          ld_status = STAT_EXPIRED;
          ld_id     = rd.id;
          ld_handle = rd.handle;
          ld_fired  = 1'b1;
          ld_last   = (ptr_q + CNT_W'(1) == due_q);
          ptr_d     = ld_last ? '0 : ptr_q + CNT_W'(1);
        end
      end
      S_M_RD: req.raddr = IDX_W'(ptr_q + due_q);
      S_M_WR: begin
        req.we = 1'b1;
        ptr_d  = ptr_q + CNT_W'(1);
      end
      S_RESP: out_load = out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      next_id_q   <= '0;
      head_q      <= '0;
      ptr_q       <= '0;
      due_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      head_q    <= head_d;
      ptr_q     <= ptr_d;
      due_q     <= due_d;
      found_q   <= found_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q       <= time_d;
    handle_q     <= handle_d;
    tid_q        <= tid_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    if (out_load) begin
      out_status_q <= ld_status;
      out_id_q     <= ld_id;
      out_handle_q <= ld_handle;
      out_fired_q  <= ld_fired;
      out_last_q   <= ld_last;
      out_hv_q     <= (count_q != '0);
      out_head_q   <= (count_q != '0) ? head_q : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_head_q, out_hv_q, out_handle_q, out_id_q};
  assign m_axis_tuser  = {out_fired_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: src/teq_chk.sv
module teq_chk
  import teq_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic [3:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_fired_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] == STAT_EXPIRED)
    else $error("fired result with wrong status");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[64] |-> m_axis_tdata[128:65] == 64'd0)
    else $error("empty queue with nonzero head");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tlast)
    else $error("single result not marked last");

endmodule

bind timer_event_queue teq_chk u_teq_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

FILE: bench/tb_timer_event_queue.sv
module tb_timer_event_queue;
  import teq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int N_RANDOM = 285;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] expire_time;
    logic [31:0] handle;
    logic [31:0] target_id;
    logic [63:0] now_time;
  } timer_req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] evt_id;
    logic [31:0] out_handle;
    logic        fired;
    logic        head_valid;
    logic [63:0] head_time;
    logic        last;
  } timer_res_t;

  typedef struct {
    timer_req_t req;
    bit         typed;
    timer_res_t want;
  } directed_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         m_axis_tlast;

  entry_t        pending_events[$];
  timer_res_t    step_results[$];
  timer_res_t    expected_results[$];
  directed_row_t directed_rows[$];
  logic [31:0]   next_evt_id = '0;
  logic [63:0]   wall_ns = '0;
  bit            steady = 1'b0;
  int            mismatches = 0;
  int            cycle_count = 0;
  timer_res_t    want_res;
  timer_req_t    rand_req;

  timer_event_queue dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready = steady || ($urandom_range(0, 99) >= 10);
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d, %s: got %h, want %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", {61'd0, m_axis_tuser[2:0]}, '0);
      end else begin
        want_res = expected_results.pop_front();
        if (m_axis_tuser[2:0] !== want_res.status)
          report_mismatch("status", 64'(m_axis_tuser[2:0]), 64'(want_res.status));
        if (m_axis_tdata[31:0] !== want_res.evt_id)
          report_mismatch("evt_id", 64'(m_axis_tdata[31:0]), 64'(want_res.evt_id));
        if (m_axis_tdata[63:32] !== want_res.out_handle)
          report_mismatch("out_handle", 64'(m_axis_tdata[63:32]), 64'(want_res.out_handle));
        if (m_axis_tuser[3] !== want_res.fired)
          report_mismatch("fired", 64'(m_axis_tuser[3]), 64'(want_res.fired));
        if (m_axis_tdata[64] !== want_res.head_valid)
          report_mismatch("head_valid", 64'(m_axis_tdata[64]), 64'(want_res.head_valid));
        if (m_axis_tdata[128:65] !== want_res.head_time)
          report_mismatch("head_time", m_axis_tdata[128:65], want_res.head_time);
        if (m_axis_tlast !== want_res.last)
          report_mismatch("last", 64'(m_axis_tlast), 64'(want_res.last));
      end
    end
  end

  // Apply one request to the local event list and collect its results.
  task automatic predict_request(timer_req_t r);
    int         pos;
    entry_t     ev;
    timer_res_t res;
    step_results.delete();
    res = '0;
    res.status = STAT_EXPIRED;
    case (r.cmd)
      CMD_CREATE: begin
        if (pending_events.size() >= QUEUE_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          pos = 0;
          while (pos < pending_events.size() && pending_events[pos].expiry <= r.expire_time)
            pos++;
          ev.expiry = r.expire_time;
          ev.id = next_evt_id;
          ev.handle = r.handle;
          pending_events.insert(pos, ev);
          res.status = STAT_CREATED;
          res.evt_id = next_evt_id;
          next_evt_id++;
        end
        step_results.push_back(res);
      end
      CMD_CANCEL: begin
        pos = 0;
        while (pos < pending_events.size() && pending_events[pos].id != r.target_id)
          pos++;
        if (pos < pending_events.size()) begin
          pending_events.delete(pos);
          res.status = STAT_CANCELLED;
        end else begin
          res.status = STAT_NOT_FOUND;
        end
        res.evt_id = r.target_id;
        step_results.push_back(res);
      end
      CMD_EXPIRE: begin
        while (step_results.size() < MAX_RESULTS && pending_events.size() > 0 &&
               pending_events[0].expiry <= r.now_time) begin
          ev = pending_events.pop_front();
          res = '0;
          res.status = STAT_EXPIRED;
          res.evt_id = ev.id;
          res.out_handle = ev.handle;
          res.fired = 1'b1;
          step_results.push_back(res);
        end
        if (step_results.size() == 0)
          step_results.push_back(res);
      end
      default: begin
        step_results.push_back(res);
      end
    endcase
    foreach (step_results[k]) begin
      step_results[k].head_valid = pending_events.size() > 0;
      step_results[k].head_time = pending_events.size() > 0 ? pending_events[0].expiry : '0;
      step_results[k].last = (k == step_results.size() - 1);
    end
  endtask

  task automatic send_request(timer_req_t r);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {r.now_time, r.target_id, r.handle, r.expire_time};
    s_axis_tuser = r.cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic random_request(output timer_req_t r);
    int roll;
    int pick;
    roll = $urandom_range(0, 99);
    r.handle = $urandom;
    r.target_id = $urandom;
    r.expire_time = {$urandom, $urandom};
    r.now_time = {$urandom, $urandom};
    if (roll < 45) begin
      r.cmd = CMD_CREATE;
      pick = $urandom_range(0, 19);
      if (pick >= 1 && pick < 4 && pending_events.size() > 0)
        r.expire_time = pending_events[$urandom_range(0, pending_events.size() - 1)].expiry;
      else if (pick != 0)
        r.expire_time = wall_ns + $urandom_range(0, 500);
    end else if (roll < 65) begin
      r.cmd = CMD_CANCEL;
      pick = $urandom_range(0, 7);
      if (pick < 6 && pending_events.size() > 0)
        r.target_id = pending_events[$urandom_range(0, pending_events.size() - 1)].id;
      else if (pick == 6)
        r.target_id = next_evt_id - $urandom_range(1, 20);
    end else if (roll < 96) begin
      r.cmd = CMD_EXPIRE;
      if ($urandom_range(0, 19) != 0) begin
        wall_ns = wall_ns + $urandom_range(0, 300);
        r.now_time = wall_ns;
      end
    end else begin
      r.cmd = CMD_UNUSED;
    end
  endtask

  function automatic void add_row(logic [1:0] cmd, logic [63:0] t, logic [31:0] h,
                                  logic [31:0] tid, logic [63:0] now, bit typed = 1'b0,
                                  status_e st = STAT_EXPIRED, logic [31:0] id = '0,
                                  logic hv = 1'b0, logic [63:0] ht = '0);
    directed_row_t row;
    row.req = '{cmd: cmd, expire_time: t, handle: h, target_id: tid, now_time: now};
    row.typed = typed;
    row.want = '0;
    row.want.status = st;
    row.want.evt_id = id;
    row.want.head_valid = hv;
    row.want.head_time = ht;
    row.want.last = 1'b1;
    directed_rows.push_back(row);
  endfunction

  initial begin
    add_row(CMD_EXPIRE, '0, '0, '0, '0, 1'b1, STAT_EXPIRED, '0, 1'b0, '0);
    add_row(CMD_CREATE, '1, '1, '0, '0, 1'b1, STAT_CREATED, 32'd0, 1'b1, '1);
    add_row(CMD_CREATE, '0, '0, '0, '0, 1'b1, STAT_CREATED, 32'd1, 1'b1, '0);
    add_row(CMD_CREATE, 64'd100, 32'hA5A5_0001, '0, '0);
    add_row(CMD_CREATE, 64'd100, 32'hA5A5_0002, '0, '0);
    add_row(CMD_UNUSED, '1, '1, '1, '1, 1'b1, STAT_EXPIRED, '0, 1'b1, '0);
    add_row(CMD_EXPIRE, '0, '0, '0, 64'd100);
    for (int i = 0; i < 15; i++)
      add_row(CMD_CREATE, 64'(200 + (i % 5) * 10), 32'h100 + i, '0, '0);
    add_row(CMD_CREATE, 64'd50, 32'h5A5A_5A5A, '0, '0, 1'b1, STAT_FULL, '0, 1'b1, 64'd200);
    add_row(CMD_CANCEL, '0, '0, 32'd10, '0);
    add_row(CMD_CANCEL, '0, '0, '1, '0, 1'b1, STAT_NOT_FOUND, '1, 1'b1, 64'd200);
    add_row(CMD_EXPIRE, '0, '0, '0, '1);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req);
      predict_request(directed_rows[i].req);
      if (directed_rows[i].typed)
        expected_results.push_back(directed_rows[i].want);
      else
        foreach (step_results[k]) expected_results.push_back(step_results[k]);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      steady = (n >= 100 && n < 180);
      random_request(rand_req);
      send_request(rand_req);
      predict_request(rand_req);
      foreach (step_results[k]) expected_results.push_back(step_results[k]);
    end
    steady = 1'b0;

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
